FILE: rtl/core/egd_pkg.sv
// ----------------------------------------------------------------------------
// egd_pkg
// Shared types and constants for the order-0 Exp-Golomb bitstream decoder.
// ----------------------------------------------------------------------------
package egd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CodeW  = 32;
  localparam int unsigned ZcntW  = 6;
  localparam int unsigned LeftW  = 5;
  localparam int unsigned BitIdxW = 3;

  // One finished code as it leaves the bit parser. acc holds the prefix one
  // bit followed by the suffix bits, so the code number is acc - 1.
  typedef struct packed {
    logic [CodeW-1:0] acc;
    logic             err;
  } res_t;

endpackage

FILE: rtl/core/egd_bit_core.sv
// ----------------------------------------------------------------------------
// egd_bit_core
// Bit-serial Exp-Golomb parser: counts prefix zeros, shifts in suffix bits
// and flags a finished code (or a prefix overflow) one bit per step.
// ----------------------------------------------------------------------------
module egd_bit_core #(
  parameter int unsigned MAX_PREFIX_ZEROS = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          bit_i,
  output logic          emit_o,
  output egd_pkg::res_t res_o
);

  logic                         reading_q, reading_d;
  logic [egd_pkg::ZcntW-1:0]    zcnt_q, zcnt_d;
  logic [egd_pkg::LeftW-1:0]    left_q, left_d;
  logic [egd_pkg::CodeW-1:0]    acc_q, acc_d;
  logic [egd_pkg::ZcntW-1:0]    zcnt_inc;
  logic [egd_pkg::CodeW-1:0]    acc_shift;
  logic [egd_pkg::LeftW-1:0]    left_dec;

  assign zcnt_inc  = zcnt_q + egd_pkg::ZcntW'(1);
  assign acc_shift = {acc_q[egd_pkg::CodeW-2:0], bit_i};
  assign left_dec  = left_q - egd_pkg::LeftW'(1);

  always_comb begin
    reading_d   = reading_q;
    zcnt_d      = zcnt_q;
    left_d      = left_q;
    acc_d       = acc_q;
    emit_o      = 1'b0;
    res_o.acc   = acc_shift;
    res_o.err   = 1'b0;
    if (!reading_q) begin
      if (!bit_i) begin
        if (zcnt_inc > egd_pkg::ZcntW'(MAX_PREFIX_ZEROS)) begin
          // prefix too long: error result, start over with the next bit
          emit_o    = 1'b1;
          res_o.err = 1'b1;
          zcnt_d    = '0;
        end else begin
          zcnt_d = zcnt_inc;
        end
      end else if (zcnt_q == '0) begin
        emit_o    = 1'b1;
        res_o.acc = egd_pkg::CodeW'(1);
      end else begin
        reading_d = 1'b1;
        left_d    = zcnt_q[egd_pkg::LeftW-1:0];
        acc_d     = egd_pkg::CodeW'(1);
      end
    end else begin
      acc_d  = acc_shift;
      left_d = left_dec;
      if (left_dec == '0) begin
        emit_o    = 1'b1;
        reading_d = 1'b0;
        zcnt_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reading_q <= 1'b0;
      zcnt_q    <= '0;
      left_q    <= '0;
      acc_q     <= '0;
    end else if (step_i) begin
      reading_q <= reading_d;
      zcnt_q    <= zcnt_d;
      left_q    <= left_d;
      acc_q     <= acc_d;
    end
  end

endmodule

FILE: rtl/core/exp_golomb_bitstream_decoder.sv
// Hold: a result is held until the next code of the same byte ends or the
//   byte runs out.
// Throughput: one stream bit per cycle while the output keeps up; a flush
//   phase hands over the final result and can already take the next byte.
// Reset: rst_ni clears the parser, the control flags and the valid bits.
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_decoder
// Order-0 Exp-Golomb decoder over a byte stream, MSB first, with optional
// signed mapping and per-byte last-result marking.
// ----------------------------------------------------------------------------
module exp_golomb_bitstream_decoder #(
  parameter int unsigned MAX_PREFIX_ZEROS = 31
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [egd_pkg::ByteW-1:0]  stream_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [egd_pkg::CodeW-1:0]  code_number_o,
  output logic signed [egd_pkg::CodeW-1:0] signed_value_o,
  output logic                       overflow_error_o,
  output logic                       last_of_byte_o
);

  logic                         signed_mode_q;
  logic [egd_pkg::ByteW-1:0]    byte_q;
  logic [egd_pkg::BitIdxW-1:0]  bit_idx_q;
  logic                         busy_q;
  logic                         flush_q;
  logic                         pend_v_q;
  egd_pkg::res_t                pend_q;
  logic                         out_valid_q;
  logic [egd_pkg::CodeW-1:0]    code_q;
  logic [egd_pkg::CodeW-1:0]    sval_q;
  logic                         err_q;
  logic                         last_q;

  logic                         emit;
  egd_pkg::res_t                res;
  logic                         out_free;
  logic                         step;
  logic                         flush_done;
  logic                         in_acc;
  logic                         load_out;
  logic                         load_last;
  logic [egd_pkg::CodeW-1:0]    mag;
  logic [egd_pkg::CodeW-1:0]    code_calc;
  logic [egd_pkg::CodeW-1:0]    sval_calc;

  assign out_free   = !out_valid_q || out_ready_i;
  // a new result needs the hold slot; the held one must move to the output
  assign step       = busy_q && !flush_q && !(emit && pend_v_q && !out_free);
  assign flush_done = !pend_v_q || out_free;
  assign in_ready_o = !busy_q || (flush_q && flush_done);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_out   = (step && emit && pend_v_q) || (flush_q && pend_v_q && out_free);
  assign load_last  = flush_q;

  egd_bit_core #(
    .MAX_PREFIX_ZEROS(MAX_PREFIX_ZEROS)
  ) u_bit_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .bit_i  (byte_q[egd_pkg::ByteW-1]),
    .emit_o (emit),
    .res_o  (res)
  );

  // code = acc - 1; signed magnitude = (code + 1) >> 1 = acc >> 1
  assign mag       = {1'b0, pend_q.acc[egd_pkg::CodeW-1:1]};
  assign code_calc = pend_q.err ? '0 : (pend_q.acc - egd_pkg::CodeW'(1));
  always_comb begin
    sval_calc = '0;
    if (!pend_q.err && signed_mode_q) begin
      sval_calc = pend_q.acc[0] ? (~mag + egd_pkg::CodeW'(1)) : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      signed_mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      flush_q   <= 1'b0;
      bit_idx_q <= '0;
    end else if (in_acc) begin
      busy_q    <= 1'b1;
      flush_q   <= 1'b0;
      bit_idx_q <= '0;
    end else if (flush_q && flush_done) begin
      busy_q  <= 1'b0;
      flush_q <= 1'b0;
    end else if (step) begin
      bit_idx_q <= bit_idx_q + egd_pkg::BitIdxW'(1);
      if (bit_idx_q == '1) begin
        flush_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= stream_byte_i;
    end else if (step) begin
      byte_q <= {byte_q[egd_pkg::ByteW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (step && emit) begin
      pend_v_q <= 1'b1;
    end else if (flush_q && out_free) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      pend_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      code_q <= code_calc;
      sval_q <= sval_calc;
      err_q  <= pend_q.err;
      last_q <= load_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_number_o    = code_q;
  assign signed_value_o   = sval_q;
  assign overflow_error_o = err_q;
  assign last_of_byte_o   = last_q;

`ifndef SYNTH
  a_pend_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !pend_v_q)
    else $error("held result outside of a byte");

  a_flush_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> busy_q)
    else $error("flush phase while idle");

  a_new_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !pend_v_q)
    else $error("result of previous byte still held at new request");

  a_err_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_error_o) |-> (code_number_o == '0 && signed_value_o == '0))
    else $error("error result with nonzero value");
`endif

endmodule

FILE: tb/exp_golomb_bitstream_decoder_tb.sv
// ----------------------------------------------------------------------------
// exp_golomb_bitstream_decoder_tb
// Drives byte requests into the order-0 Exp-Golomb decoder and checks every
// decoded code against a bit-serial predictor kept in the bench. The run has
// directed streams for the edge codes, random well-formed code streams with
// noise, and an output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module exp_golomb_bitstream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPrefixZeros = 31;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned SettleCycles   = 16;
  localparam int unsigned ReportLimit    = 10;
  localparam logic        ModeUnsigned   = 1'b0;
  localparam logic        ModeSigned     = 1'b1;

  typedef struct packed {
    logic [egd_pkg::CodeW-1:0] code;
    logic [egd_pkg::CodeW-1:0] sval;
    logic                      err;
    logic                      last;
  } code_res_t;

  logic                             clk_i;
  logic                             rst_ni        = 1'b0;
  logic                             cfg_we_i      = 1'b0;
  logic                             cfg_wdata_i   = 1'b0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_ready_o;
  logic [egd_pkg::ByteW-1:0]        stream_byte_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i   = 1'b0;
  logic [egd_pkg::CodeW-1:0]        code_number_o;
  logic signed [egd_pkg::CodeW-1:0] signed_value_o;
  logic                             overflow_error_o;
  logic                             last_of_byte_o;

  // predictor state, mirrors the block after reset
  logic                      mode_q           = ModeUnsigned;
  logic                      in_suffix        = 1'b0;
  logic [egd_pkg::ZcntW-1:0] zeros_seen       = '0;
  logic [egd_pkg::LeftW-1:0] suffix_bits_left = '0;
  logic [egd_pkg::CodeW-1:0] suffix_acc       = '0;

  code_res_t pending_codes[$];
  logic      bit_pool[$];
  int        tx_idle_pct  = 0;
  int        rx_stall_pct = 0;
  int        hold_left    = 0;
  int        fail_count   = 0;

  exp_golomb_bitstream_decoder #(
    .MAX_PREFIX_ZEROS(MaxPrefixZeros)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .stream_byte_i   (stream_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .code_number_o   (code_number_o),
    .signed_value_o  (signed_value_o),
    .overflow_error_o(overflow_error_o),
    .last_of_byte_o  (last_of_byte_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic code_res_t make_code(input logic [egd_pkg::CodeW-1:0] code,
                                          input logic err);
    code_res_t                 r;
    logic [egd_pkg::CodeW-1:0] mag;
    mag    = (code >> 1) + egd_pkg::CodeW'(code[0]);
    r.code = err ? '0 : code;
    // even code numbers map to the negative side
    r.sval = (err || !mode_q) ? '0 : (code[0] ? mag : -mag);
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void restart_parse();
    in_suffix        = 1'b0;
    zeros_seen       = '0;
    suffix_bits_left = '0;
    suffix_acc       = '0;
  endfunction

  function automatic void add_pool_bit(input logic v);
    bit_pool.insert(bit_pool.size(), v);
  endfunction

  function automatic void predict_codes(input logic [egd_pkg::ByteW-1:0] b);
    code_res_t                 batch[egd_pkg::ByteW];
    int                        n_out;
    int                        i;
    logic                      bit_v;
    logic [egd_pkg::CodeW-1:0] code;
    n_out = 0;
    for (i = egd_pkg::ByteW - 1; i >= 0; i--) begin
      bit_v = b[i];
      if (!in_suffix) begin
        if (!bit_v) begin
          zeros_seen = zeros_seen + egd_pkg::ZcntW'(1);
          if (zeros_seen > MaxPrefixZeros) begin
            batch[n_out] = make_code('0, 1'b1);
            n_out++;
            restart_parse();
          end
        end else if (zeros_seen == '0) begin
          batch[n_out] = make_code('0, 1'b0);
          n_out++;
          restart_parse();
        end else begin
          in_suffix        = 1'b1;
          suffix_bits_left = zeros_seen[egd_pkg::LeftW-1:0];
          suffix_acc       = '0;
        end
      end else begin
        suffix_acc       = {suffix_acc[egd_pkg::CodeW-2:0], bit_v};
        suffix_bits_left = suffix_bits_left - egd_pkg::LeftW'(1);
        if (suffix_bits_left == '0) begin
          code = ((32'd1 << zeros_seen[egd_pkg::LeftW-1:0]) - 32'd1) + suffix_acc;
          batch[n_out] = make_code(code, 1'b0);
          n_out++;
          restart_parse();
        end
      end
    end
    if (n_out > 0) begin
      batch[n_out-1].last = 1'b1;
    end
    for (i = 0; i < n_out; i++) begin
      pending_codes.insert(pending_codes.size(), batch[i]);
    end
  endfunction

  // next chunk of a random stream: mostly whole codes, some overlong prefixes
  // and raw noise bits
  function automatic void grow_stream();
    int pick;
    int n;
    int i;
    pick = $urandom_range(99);
    if (pick < 8) begin
      for (i = 0; i < egd_pkg::ByteW; i++) begin
        add_pool_bit($urandom_range(1) != 0);
      end
    end else if (pick < 13) begin
      n = $urandom_range(MaxPrefixZeros + 9, MaxPrefixZeros + 1);
      for (i = 0; i < n; i++) begin
        add_pool_bit(1'b0);
      end
    end else begin
      if (pick < 60) begin
        n = $urandom_range(3, 0);
      end else if (pick < 85) begin
        n = $urandom_range(12, 4);
      end else begin
        n = $urandom_range(MaxPrefixZeros, 13);
      end
      for (i = 0; i < n; i++) begin
        add_pool_bit(1'b0);
      end
      add_pool_bit(1'b1);
      for (i = 0; i < n; i++) begin
        add_pool_bit($urandom_range(1) != 0);
      end
    end
  endfunction

  task automatic send_byte(input logic [egd_pkg::ByteW-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    predict_codes(b);
  endtask

  task automatic wait_idle();
    while (pending_codes.size() != 0) begin
      @(posedge clk_i);
    end
    // a byte that ends no code may still be in the shifter
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic mode);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_q = mode;
  endtask

  task automatic run_random(input int n_bytes, input int tx_pct, input int rx_pct,
                            input logic mode);
    logic [egd_pkg::ByteW-1:0] b;
    int                        k;
    int                        i;
    set_mode(mode);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (k = 0; k < n_bytes; k++) begin
      while (bit_pool.size() < egd_pkg::ByteW) begin
        grow_stream();
      end
      for (i = 0; i < egd_pkg::ByteW; i++) begin
        b = {b[egd_pkg::ByteW-2:0], bit_pool.pop_front()};
      end
      send_byte(b);
    end
    in_valid_i <= 1'b0;
  endtask

  // lone one bits, then 31 zeros with an all-ones suffix for the largest code
  task automatic test_unsigned_edges();
    logic [egd_pkg::ByteW-1:0] seq [11] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF,
                                            8'hFF, 8'hFF, 8'hFF, 8'h40, 8'hA5};
    set_mode(ModeUnsigned);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    foreach (seq[i]) send_byte(seq[i]);
    in_valid_i <= 1'b0;
  endtask

  // signed mapping, overlong prefix error and the largest code again
  task automatic test_signed_edges();
    logic [egd_pkg::ByteW-1:0] seq [14] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                            8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF,
                                            8'hFF, 8'h5A};
    set_mode(ModeSigned);
    foreach (seq[i]) send_byte(seq[i]);
    in_valid_i <= 1'b0;
  endtask

  task automatic test_random_streams();
    run_random(104, 0, 0, ModeUnsigned);
    run_random(104, 59, 0, ModeSigned);
    run_random(104, 0, 59, ModeUnsigned);
    run_random(104, 15, 15, ModeSigned);
  endtask

  // receiver holds off while dense bytes keep coming, so the block backs up
  task automatic test_output_hold_off();
    int k;
    set_mode(ModeUnsigned);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 400;
    for (k = 0; k < 30; k++) begin
      send_byte(($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'hFF);
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    code_res_t got;
    code_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.code = code_number_o;
      got.sval = signed_value_o;
      got.err  = overflow_error_o;
      got.last = last_of_byte_o;
      if (pending_codes.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $display("unexpected code: code=%0d sval=%0d err=%0b last=%0b",
                   got.code, $signed(got.sval), got.err, got.last);
        end
      end else begin
        want = pending_codes.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("code mismatch: exp code=%0d sval=%0d err=%0b last=%0b",
                     want.code, $signed(want.sval), want.err, want.last);
            $display("               got code=%0d sval=%0d err=%0b last=%0b",
                     got.code, $signed(got.sval), got.err, got.last);
          end
        end
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[exp_golomb_bitstream_decoder] ERROR");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unsigned_edges();
    test_signed_edges();
    test_random_streams();
    test_output_hold_off();
    wait_idle();
    if (fail_count == 0) begin
      $display("[exp_golomb_bitstream_decoder] OK");
    end else begin
      $display("[exp_golomb_bitstream_decoder] ERROR");
    end
    $finish;
  end

endmodule
